// ----- rtl/core/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg: shared constants for the buddy page allocator
// Field widths and stream packing of the request and result channels.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MODE_W  = 1;
    localparam int REQ_W   = 4;
    localparam int PAGE_W  = 10;
    localparam int ZONE_W  = 11;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [ZONE_W-1:0] ZONE_RESET = 11'd1024;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic REG_ZONE_PAGES = 1'b0;

endpackage

// ----- rtl/core/buddy_page_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_page_allocator: buddy allocator over a zone of pages
// Free lists per order; links and recorded orders live in on-chip memories.
// ----------------------------------------------------------------------------
// Allocate: the orders are searched upward from the one requested, the block
// found is split a level at a time down to it, and the head is popped; an
// out-of-range order fails with no search. Free: the recorded order is read,
// the block merges with its buddy while the buddy is in the list below the top
// order, then is pushed. One request is in work at a time; a pending result
// that cannot reach a stalled output holds s_tready low. Reset (synchronous,
// aresetn low) sets zone_pages to 1024 and rebuilds the lists before ready.
module buddy_page_allocator #(
    parameter int PAGES  = 1024,
    parameter int ORDERS = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [3:0] req_order, [13:4] page_index, [15:14] zero
    input  logic [bpa_pkg::IN_W-1:0]    s_tdata,
    // [0] mode
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [9:0] block_page, [15:10] zero
    output logic [bpa_pkg::OUT_W-1:0]   m_tdata,
    // [0] status
    output logic                        m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpa_pkg::APB_AW-1:0]  paddr,
    input  logic [bpa_pkg::APB_DW-1:0]  pwdata,
    output logic [bpa_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import bpa_pkg::*;

    localparam int AW  = $clog2(PAGES);
    localparam int CW  = $clog2(PAGES + 1);
    localparam int OW  = $clog2(ORDERS);
    localparam int OCW = $clog2(ORDERS + 1);
    localparam int TOP = ORDERS - 1;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_BINIT  = 16'h0002,
        ST_BTOP   = 16'h0004,
        ST_BLOW   = 16'h0008,
        ST_SEARCH = 16'h0010,
        ST_SPL_RD = 16'h0020,
        ST_SPL_W1 = 16'h0040,
        ST_SPL_W2 = 16'h0080,
        ST_SPL_W3 = 16'h0100,
        ST_POP_RD = 16'h0200,
        ST_POP_WR = 16'h0400,
        ST_F_ORD  = 16'h0800,
        ST_MERGE  = 16'h1000,
        ST_REM_RD = 16'h2000,
        ST_REM_CK = 16'h4000,
        ST_PUSH   = 16'h8000
    } state_t;

    state_t             state_reg, state_next;
    logic [ZONE_W-1:0]  zone_reg;
    logic [AW-1:0]      head_reg  [ORDERS];
    logic [CW-1:0]      count_reg [ORDERS];
    logic [OCW-1:0]     o_reg, o_next;
    logic [OCW-1:0]     req_reg, req_next;
    logic [AW-1:0]      p_reg, p_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [AW-1:0]      prev_reg, prev_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               res_pend_reg, res_pend_next;
    logic               res_st_reg, res_st_next;
    logic [PAGE_W-1:0]  res_pg_reg, res_pg_next;
    logic               out_st_reg;
    logic [PAGE_W-1:0]  out_pg_reg;
    logic               m_valid_reg;

    logic [AW-1:0]      link_mem [PAGES];
    logic [OW-1:0]      ord_mem  [PAGES];
    logic [AW-1:0]      link_rdata, link_raddr, link_waddr, link_wdata;
    logic               link_we;
    logic [OW-1:0]      ord_rdata;
    logic [AW-1:0]      ord_raddr;
    logic               ord_we;

    logic               cfg_we, s_acc, out_free;
    logic [31:0]        n32, nb32, buddy32;
    logic [OW-1:0]      oi;
    logic               hc_we;
    logic [AW-1:0]      hc_head;
    logic [CW-1:0]      hc_count;
    logic [OW-1:0]      ord_clamp;
    logic               in_mode;
    logic [REQ_W-1:0]   in_req;
    logic [PAGE_W-1:0]  in_page;

    assign in_mode = s_tuser;
    assign in_req  = s_tdata[REQ_W-1:0];
    assign in_page = s_tdata[REQ_W+PAGE_W-1:REQ_W];

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && (paddr[2] == REG_ZONE_PAGES);
    assign prdata   = (paddr[2] == REG_ZONE_PAGES) ? APB_DW'(zone_reg) : '0;
    assign s_tready = (state_reg == ST_IDLE) && !res_pend_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_W - PAGE_W)'(0), out_pg_reg};
    assign m_tuser  = out_st_reg;

    assign n32     = (32'(zone_reg) > PAGES) ? PAGES : 32'(zone_reg);
    assign nb32    = n32 >> TOP;
    assign oi      = o_reg[OW-1:0];
    assign buddy32 = 32'(p_reg) ^ (32'd1 << o_reg);
    assign ord_clamp = (32'(ord_rdata) > TOP) ? OW'(TOP) : ord_rdata;

    // Memories: one write port, registered read.
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[link_raddr];
        if (ord_we) begin
            ord_mem[p_reg] <= req_reg[OW-1:0];
        end
        ord_rdata <= ord_mem[ord_raddr];
    end

    always_comb begin
        state_next    = state_reg;
        o_next        = o_reg;
        req_next      = req_reg;
        p_next        = p_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        idx_next      = idx_reg;
        res_pend_next = res_pend_reg;
        res_st_next   = res_st_reg;
        res_pg_next   = res_pg_reg;
        link_we       = 1'b0;
        link_waddr    = p_reg;
        link_wdata    = head_reg[oi];
        link_raddr    = head_reg[oi];
        ord_raddr     = AW'(in_page);
        ord_we        = 1'b0;
        hc_we         = 1'b0;
        hc_head       = head_reg[oi];
        hc_count      = count_reg[oi];

        if (res_pend_reg && out_free) begin
            res_pend_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    res_st_next = STATUS_OK;
                    res_pg_next = '0;
                    if (in_mode == MODE_ALLOC) begin
                        if (32'(in_req) >= ORDERS) begin
                            res_st_next   = STATUS_FAIL;
                            res_pend_next = 1'b1;
                        end else begin
                            o_next     = OCW'(in_req);
                            req_next   = OCW'(in_req);
                            state_next = ST_SEARCH;
                        end
                    end else if (32'(in_page) >= PAGES) begin
                        res_pend_next = 1'b1;
                    end else begin
                        p_next     = AW'(in_page);
                        state_next = ST_F_ORD;
                    end
                end
            end
            ST_BINIT: begin
                idx_next   = '0;
                state_next = ST_BTOP;
            end
            ST_BTOP: begin
                // Top-order blocks are chained in ascending address order.
                if (32'(idx_reg) == nb32) begin
                    o_next     = OCW'(TOP);
                    state_next = ST_BLOW;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = AW'(32'(idx_reg) << TOP);
                    link_wdata = (32'(idx_reg) + 32'd1 < nb32)
                               ? AW'((32'(idx_reg) + 32'd1) << TOP) : '0;
                    idx_next   = idx_reg + CW'(1);
                end
            end
            ST_BLOW: begin
                // Each lower order holds at most one block, the list tail.
                if (o_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    link_we    = n32[o_reg - OCW'(1)];
                    link_waddr = AW'(n32 & ~((32'd2 << (o_reg - OCW'(1))) - 32'd1));
                    link_wdata = '0;
                    o_next     = o_reg - OCW'(1);
                end
            end
            ST_SEARCH: begin
                if (32'(o_reg) >= ORDERS) begin
                    res_st_next   = STATUS_FAIL;
                    res_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end else if (count_reg[oi] != '0) begin
                    state_next = (o_reg == req_reg) ? ST_POP_RD : ST_SPL_RD;
                end else begin
                    o_next = o_reg + OCW'(1);
                end
            end
            ST_SPL_RD: begin
                p_next     = head_reg[oi];
                state_next = ST_SPL_W1;
            end
            ST_SPL_W1: begin
                hc_we      = 1'b1;
                hc_head    = link_rdata;
                hc_count   = count_reg[oi] - CW'(1);
                o_next     = o_reg - OCW'(1);
                state_next = ST_SPL_W2;
            end
            ST_SPL_W2: begin
                link_we    = 1'b1;
                link_waddr = p_reg + (AW'(1) << o_reg);
                link_wdata = head_reg[oi];
                state_next = ST_SPL_W3;
            end
            ST_SPL_W3: begin
                // The lower half goes to the head, ahead of its upper buddy.
                link_we    = 1'b1;
                link_waddr = p_reg;
                link_wdata = p_reg + (AW'(1) << o_reg);
                hc_we      = 1'b1;
                hc_head    = p_reg;
                hc_count   = count_reg[oi] + CW'(2);
                state_next = (o_reg == req_reg) ? ST_POP_RD : ST_SPL_RD;
            end
            ST_POP_RD: begin
                p_next     = head_reg[oi];
                state_next = ST_POP_WR;
            end
            ST_POP_WR: begin
                hc_we         = 1'b1;
                hc_head       = link_rdata;
                hc_count      = count_reg[oi] - CW'(1);
                ord_we        = 1'b1;
                res_pg_next   = PAGE_W'(p_reg);
                res_pend_next = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_F_ORD: begin
                o_next     = OCW'(ord_clamp);
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                cur_next   = head_reg[oi];
                idx_next   = '0;
                state_next = (32'(o_reg) == TOP) ? ST_PUSH : ST_REM_RD;
            end
            ST_REM_RD: begin
                link_raddr = cur_reg;
                state_next = (idx_reg == count_reg[oi]) ? ST_PUSH : ST_REM_CK;
            end
            ST_REM_CK: begin
                if (32'(cur_reg) == buddy32) begin
                    if (idx_reg == '0) begin
                        hc_head = link_rdata;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = link_rdata;
                    end
                    hc_we      = 1'b1;
                    hc_count   = count_reg[oi] - CW'(1);
                    p_next     = p_reg & ~(AW'(1) << o_reg);
                    o_next     = o_reg + OCW'(1);
                    state_next = ST_MERGE;
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_REM_RD;
                end
            end
            ST_PUSH: begin
                link_we       = 1'b1;
                link_waddr    = p_reg;
                link_wdata    = head_reg[oi];
                hc_we         = 1'b1;
                hc_head       = p_reg;
                hc_count      = count_reg[oi] + CW'(1);
                res_pend_next = 1'b1;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            state_next = ST_BINIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_BINIT;
            zone_reg     <= ZONE_RESET;
            res_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            res_pend_reg <= res_pend_next;
            if (cfg_we) begin
                zone_reg <= pwdata[ZONE_W-1:0];
            end
            if (res_pend_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        o_reg      <= o_next;
        req_reg    <= req_next;
        p_reg      <= p_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        idx_reg    <= idx_next;
        res_st_reg <= res_st_next;
        res_pg_reg <= res_pg_next;
        if (res_pend_reg && out_free) begin
            out_st_reg <= res_st_reg;
            out_pg_reg <= res_pg_reg;
        end
        if (state_reg == ST_BINIT) begin
            for (int k = 0; k < ORDERS; k++) begin
                if (k == TOP) begin
                    head_reg[k]  <= '0;
                    count_reg[k] <= CW'(nb32);
                end else begin
                    head_reg[k]  <= AW'(n32 & ~((32'd2 << k) - 32'd1));
                    count_reg[k] <= CW'(n32[k]);
                end
            end
        end else if (hc_we) begin
            head_reg[oi]  <= hc_head;
            count_reg[oi] <= hc_count;
        end
    end

    a_no_link_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !link_we)
        else $error("link memory written while idle");

    a_order_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(o_reg) <= ORDERS || state_reg == ST_IDLE || state_reg == ST_BINIT
        || state_reg == ST_BTOP)
        else $error("order counter out of range");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (state_reg != ST_IDLE || res_pend_reg || cfg_we == 1'b1
        || $past(cfg_we)))
        else $error("accepted request produced no work");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_POP_WR |-> count_reg[oi] != '0)
        else $error("pop from an empty free list");

endmodule
